// ===== design/msts_pkg.sv =====
// Shared types, constants and elaboration-time functions for the multi-tone sine synthesizer.
// Used by msts_tone_cell, msts_div and multi_tone_sine_synth; depends on nothing else.
`timescale 1ns / 1ps
package msts_pkg;

  // Default sizes.
  localparam int DEF_MAX_TONES        = 16;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_PHASE_BITS       = 32;

  // Fixed field widths.
  localparam int TONE_INDEX_W = 4;
  localparam int STEP_IN_W    = 32;
  localparam int TONE_COUNT_W = 5;
  localparam int AMPLITUDE_W  = 15;
  localparam int SAMPLE_W     = 16;
  localparam int FRAC_W       = 15;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [TONE_COUNT_W-1:0] TONE_COUNT_RESET = TONE_COUNT_W'(1);
  localparam logic [AMPLITUDE_W-1:0]  AMPLITUDE_RESET  = AMPLITUDE_W'(16384);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TONE_COUNT = 1'b0,
    REG_AMPLITUDE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPIN,
    ST_DRAIN,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  // Q30 angle constants for building the sine table.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518853;
  localparam logic [63:0] PI_Q30      = TWO_PI_Q30 / 2;
  localparam logic [63:0] HALF_PI_Q30 = TWO_PI_Q30 / 4;

  // sin(x) for x in the first quadrant, Q30 in and out, Taylor series to degree 13.
  function automatic logic [63:0] quadrant_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if ((n & 1) != 0) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table entry k of a table with 2^log2_depth entries, Q1.15, rounded.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                           input int unsigned log2_depth);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    logic        neg;
    x   = (TWO_PI_Q30 * 64'(k)) >> log2_depth;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      neg = 1'b1;
      x   = x - PI_Q30;
    end
    if (x > HALF_PI_Q30) begin
      x = (x <= PI_Q30) ? PI_Q30 - x : 64'd0;
    end
    s = quadrant_sine(x);
    v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return neg ? SAMPLE_W'(64'd0 - v) : SAMPLE_W'(v);
  endfunction

endpackage

// ===== design/multi_tone_sine_synth.sv =====
// Top level of the multi-tone sine synthesizer: tone ring, sine table, scaling and output.
// Depends on msts_pkg, msts_tone_cell and msts_div.
`timescale 1ns / 1ps
// Usage:
// Items arrive on the s_ stream channel. s_tuser carries the operation: a load transaction
// (op 0) stores the phase step of the tone named in s_tdata, a tick transaction (op 1) makes
// one audio sample, which leaves on the m_ stream channel. Loads produce no output.
// The cfg_ write channel sets tone_count (index 0) and amplitude (index 1); it is always
// ready and should only be used while the block is idle.
// A load is taken while idle and leaves s_tready high. A tick holds s_tready low from
// acceptance until its sample is done, and the sample appears in the output register at
// the edge at which s_tready rises again. The tick's length is set by the tone ring, which
// rotates once through all MAX_TONES cells past the single sine table port, and by the
// serial divider that averages over the tone count one quotient bit per cycle.
// Reset clears every phase accumulator, restores tone_count to 1 and amplitude to 16384,
// and empties the output register. Phase steps are undefined until loaded.
// When the receiver stalls, the finished sample waits in the output register; a following
// load is still taken, and the next tick runs up to its final step and then waits there
// until the output register is free.
module multi_tone_sine_synth import msts_pkg::*; #(
  parameter int MAX_TONES        = DEF_MAX_TONES,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = DEF_PHASE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [39:0]            s_tdata,   // [3:0] tone_index, [35:4] phase_step, rest zero
  input  logic                   s_tuser,   // [0] op
  // Output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_W-1:0]    m_tdata,   // [15:0] sample
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int CNT_W  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int NW     = $clog2(MAX_TONES + 1);
  localparam int SUM_W  = 17 + $clog2(MAX_TONES);
  localparam int PROD_W = SUM_W + AMPLITUDE_W + 1;
  localparam int DW     = PROD_W - FRAC_W;

  // Unpack the input transaction.
  logic [TONE_INDEX_W-1:0] tone_index;
  logic [STEP_IN_W-1:0]    phase_step;
  op_t                     op;

  assign tone_index = s_tdata[TONE_INDEX_W-1:0];
  assign phase_step = s_tdata[TONE_INDEX_W +: STEP_IN_W];
  assign op         = op_t'(s_tuser);

  // Configuration registers.
  logic [TONE_COUNT_W-1:0] tone_count;
  logic [AMPLITUDE_W-1:0]  amplitude;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_count <= TONE_COUNT_RESET;
      amplitude  <= AMPLITUDE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TONE_COUNT: tone_count <= cfg_data[TONE_COUNT_W-1:0];
        REG_AMPLITUDE:  amplitude  <= cfg_data[AMPLITUDE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Control.
  state_t state;
  state_t state_next;
  logic   ring_shift;
  logic   div_start;
  logic   div_done;
  logic   out_load;
  logic   out_free;
  logic   in_accept;
  logic   tick_accept;
  logic   load_accept;

  logic [CNT_W-1:0] spin_cnt;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    n_eff_next;
  logic             spin_last;
  logic             active;

  assign out_free    = !m_tvalid || m_tready;
  assign in_accept   = s_tvalid && s_tready;
  assign tick_accept = in_accept && (op == OP_TICK);
  assign load_accept = in_accept && (op == OP_LOAD);
  assign spin_last   = (spin_cnt == CNT_W'(MAX_TONES - 1));
  assign active      = int'(spin_cnt) < int'(n_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (tick_accept) state_next = ST_SPIN;
      ST_SPIN:   if (spin_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_MUL;
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    ring_shift = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_SPIN:   ring_shift = 1'b1;
      ST_DSTART: div_start = 1'b1;
      ST_OUT:    out_load = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A tone count of zero acts as one; above the ring size it acts as the ring size.
  always_comb begin
    if (tone_count == '0) begin
      n_eff_next = NW'(1);
    end else if (int'(tone_count) > MAX_TONES) begin
      n_eff_next = NW'(MAX_TONES);
    end else begin
      n_eff_next = NW'(tone_count);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      n_eff    <= n_eff_next;
      spin_cnt <= '0;
    end else if (ring_shift) begin
      spin_cnt <= spin_cnt + CNT_W'(1);
    end
  end

  // Tone ring. Cell 0 is the head; the updated head re-enters at the tail, so after a full
  // rotation every cell again holds its own tone.
  logic [PHASE_BITS-1:0] ring_phase [MAX_TONES];
  logic [PHASE_BITS-1:0] ring_step  [MAX_TONES];
  logic [PHASE_BITS-1:0] tail_phase;
  logic [PHASE_BITS-1:0] load_step;

  assign load_step  = PHASE_BITS'(phase_step);
  // Inactive tones pass the head unchanged.
  assign tail_phase = ring_phase[0] + (active ? ring_step[0] : '0);

  for (genvar i = 0; i < MAX_TONES; i++) begin : g_cell
    logic [PHASE_BITS-1:0] nb_phase;
    logic [PHASE_BITS-1:0] nb_step;
    if (i == MAX_TONES - 1) begin : g_tail
      assign nb_phase = tail_phase;
      assign nb_step  = ring_step[0];
    end else begin : g_mid
      assign nb_phase = ring_phase[i + 1];
      assign nb_step  = ring_step[i + 1];
    end
    msts_tone_cell #(
      .PHASE_BITS(PHASE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ring_shift),
      .load     (load_accept && (int'(tone_index) == i)),
      .load_step(load_step),
      .phase_in (nb_phase),
      .step_in  (nb_step),
      .phase    (ring_phase[i]),
      .step     (ring_step[i])
    );
  end

  // Sine table, built at elaboration, read with a registered port at the head phase.
  logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rom_q;
  logic                       rom_vld;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, ADDR_W);
  end

  always_ff @(posedge clk) begin
    rom_q <= sine_rom[ring_phase[0][PHASE_BITS-1 -: ADDR_W]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_vld <= 1'b0;
    end else begin
      rom_vld <= ring_shift && active;
    end
  end

  // Accumulate, scale, then divide the magnitude by the tone count.
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic                     prod_neg;
  logic [DW-1:0]            quotient;
  logic [SAMPLE_W-1:0]      sample_next;

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      sum <= '0;
    end else if (rom_vld) begin
      sum <= sum + SUM_W'(rom_q);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= sum * $signed({1'b0, amplitude});
    end
    if (div_start) begin
      prod_neg <= prod[PROD_W-1];
    end
  end

  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  msts_div #(
    .DW(DW),
    .NW(NW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod_mag[PROD_W-1:FRAC_W]),
    .divisor (n_eff),
    .done    (div_done),
    .quotient(quotient)
  );

  // Truncated quotient with its sign restored, saturated to 16 bits.
  always_comb begin
    if (prod_neg) begin
      sample_next = (quotient > DW'(32768)) ? SAMPLE_MIN : SAMPLE_W'(-quotient);
    end else begin
      sample_next = (quotient > DW'(32767)) ? SAMPLE_MAX : SAMPLE_W'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= sample_next;
    end
  end

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  // A tick starts its rotation at the head with an empty accumulator.
  a_tick_start : assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> state == ST_SPIN && spin_cnt == '0 && sum == '0)
    else $error("tick did not start from a clean rotation");

  // Table reads feed the sum only from the rotation.
  a_rom_from_spin : assert property (@(posedge clk) disable iff (rst)
    rom_vld |-> $past(state) == ST_SPIN)
    else $error("table read outside the rotation");

  // A finished sample lands in a free output register.
  a_out_load : assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("finished sample was not presented");

endmodule

// ===== design/msts_tone_cell.sv =====
// One tone slot of the rotating tone ring: phase accumulator and phase step.
// Depends on msts_pkg.
`timescale 1ns / 1ps
module msts_tone_cell import msts_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  load,
  input  logic [PHASE_BITS-1:0] load_step,
  input  logic [PHASE_BITS-1:0] phase_in,
  input  logic [PHASE_BITS-1:0] step_in,
  output logic [PHASE_BITS-1:0] phase,
  output logic [PHASE_BITS-1:0] step
);

  // Phases start at zero; steps are only meaningful once loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (shift) begin
      phase <= phase_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      step <= step_in;
    end else if (load) begin
      step <= load_step;
    end
  end

endmodule

// ===== design/msts_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on msts_pkg.
`timescale 1ns / 1ps
module msts_div import msts_pkg::*; #(
  parameter int DW = 24,
  parameter int NW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    den;
  logic [NW-1:0]    rem;
  logic [NW:0]      rem_shift;
  logic             fits;

  assign rem_shift = {rem, quotient[DW-1]};
  assign fits      = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (cnt != '0) begin
      rem      <= fits ? NW'(rem_shift - {1'b0, den}) : NW'(rem_shift);
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

// ===== tb/sv/multi_tone_sine_synth_tb.sv =====
// Self-checking testbench for multi_tone_sine_synth: directed table, then random phases.
// Predicts tick samples with its own sine table and phase accumulators, unless a row types one in.
// Depends on msts_pkg and the multi_tone_sine_synth RTL.
`timescale 1ns / 1ps
module multi_tone_sine_synth_tb;
  import msts_pkg::*;

  localparam int TONES         = 16;
  localparam int LUT_DEPTH     = 1024;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int RANDOM_PHASES = 8;
  // A settle wait that covers one whole tick with room to spare.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PLAN_LEN      = 22;

  // One full turn of the table angle in Q30.
  localparam logic [63:0] TURN_Q30    = 64'd6746518853;
  localparam logic [63:0] HALF_TURN   = TURN_Q30 / 2;
  localparam logic [63:0] QUARTER_TURN = TURN_Q30 / 4;

  typedef enum {ROW_LOAD, ROW_TICK, ROW_SET_COUNT, ROW_SET_AMP} row_kind_t;

  // One directed row. For loads arg is the phase step, for register rows the value.
  typedef struct {
    row_kind_t          kind;
    logic [3:0]         tone;
    logic [31:0]        arg;
    bit                 known;
    logic signed [15:0] sample;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [39:0]            s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [SAMPLE_W-1:0]    m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor state, kept in step with every accepted transaction.
  logic signed [15:0] sine_lut [LUT_DEPTH];
  logic [31:0]        phase_of [TONES];
  logic [31:0]        step_of  [TONES];
  logic [TONES-1:0]   loaded;
  logic [4:0]         count_reg;
  logic [14:0]        amp_reg;
  logic signed [15:0] pending_samples [$];
  logic signed [15:0] oldest;

  plan_row_t   plan [PLAN_LEN];
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned cycle_count = 0;
  int          errors = 0;

  multi_tone_sine_synth u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sine table in Q1.15: first-quadrant Taylor series in Q30, folded by symmetry, rounded.
  initial begin : build_sine_lut
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] mag;
    bit          neg;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      ang = (TURN_Q30 * 64'(k)) / 64'(LUT_DEPTH);
      neg = 1'b0;
      if (ang >= HALF_TURN) begin
        neg = 1'b1;
        ang = ang - HALF_TURN;
      end
      if (ang > QUARTER_TURN) ang = (ang <= HALF_TURN) ? HALF_TURN - ang : 64'd0;
      sq   = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (acc > term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      mag = (acc * 64'd32767 + 64'd536870912) >> 30;
      if (mag > 64'd32767) mag = 64'd32767;
      sine_lut[k] = neg ? -16'(mag) : 16'(mag);
    end
  end

  // Offers one input transaction after a random gap, waits for acceptance and then
  // updates the predictor. A tick pushes its sample, or the typed-in value if known.
  task automatic send_item(input op_t op, input logic [3:0] tone, input logic [31:0] arg,
                           input bit known, input logic signed [15:0] typed);
    int unsigned n;
    longint      acc;
    longint      scaled;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, arg, tone};
    do @(posedge clk); while (!s_tready);
    if (op == OP_LOAD) begin
      step_of[tone] = arg;
      loaded[tone]  = 1'b1;
    end else begin
      // Zero tones count as one and anything past the tone limit as the limit.
      n = (count_reg == 5'd0) ? 1 : ((count_reg > TONES) ? TONES : count_reg);
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc += sine_lut[phase_of[j][31:22]];
        phase_of[j] = phase_of[j] + step_of[j];
      end
      scaled = (acc * longint'(amp_reg)) / (longint'(n) * 32768);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      pending_samples.push_back(known ? typed : 16'(scaled));
    end
    @(negedge clk);
  endtask

  // Register writes only go out once every sample is back and the block has settled.
  task automatic write_reg(input cfg_reg_t which, input logic [14:0] value);
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (which == REG_TONE_COUNT) begin
      count_reg = value[4:0];
    end else begin
      amp_reg = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // The receiver stalls at random; each accepted sample is matched against the oldest
  // prediction.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d with nothing expected", $time,
                 $signed(m_tdata));
        errors++;
      end else begin
        oldest = pending_samples.pop_front();
        if (m_tdata !== oldest) begin
          $display("%0t: sample mismatch, expected %0d, actual %0d", $time, oldest,
                   $signed(m_tdata));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_tone_sine_synth_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned eff;
    int          missing;
    int          sent;
    logic [31:0] step;
    logic [4:0]  cnt;
    logic [14:0] amp;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_LOAD;
    cfg_valid     = 1'b0;
    cfg_index     = REG_TONE_COUNT;
    cfg_data      = '0;
    src_idle_pct  = 13;
    sink_idle_pct = 79;
    count_reg     = TONE_COUNT_RESET;
    amp_reg       = AMPLITUDE_RESET;
    loaded        = '0;
    sent          = 0;
    foreach (phase_of[j]) begin
      phase_of[j] = '0;
      step_of[j]  = '0;
    end

    // Directed rows. Only a sine read at phase zero or at a half turn, or any tick at zero
    // amplitude, is typed in as zero; everything else goes through the predictor.
    plan = '{
      '{ROW_LOAD,      4'd0,  32'h0000_0000, 1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b1, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b1, 16'sd0},
      '{ROW_LOAD,      4'd0,  32'h4000_0000, 1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b1, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_LOAD,      4'd0,  32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b1, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_SET_AMP,   4'd0,  32'd0,         1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b1, 16'sd0},
      '{ROW_SET_AMP,   4'd0,  32'd32767,     1'b0, 16'sd0},
      '{ROW_LOAD,      4'd15, 32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{ROW_LOAD,      4'd1,  32'h8000_0000, 1'b0, 16'sd0},
      '{ROW_SET_COUNT, 4'd0,  32'd2,         1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_SET_COUNT, 4'd0,  32'd0,         1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_SET_COUNT, 4'd0,  32'd2,         1'b0, 16'sd0},
      '{ROW_TICK,      4'd0,  32'h0,         1'b0, 16'sd0},
      '{ROW_LOAD,      4'd0,  32'h0000_0001, 1'b0, 16'sd0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_LOAD:      send_item(OP_LOAD, plan[i].tone, plan[i].arg, 1'b0, 16'sd0);
        ROW_TICK:      send_item(OP_TICK, plan[i].tone, plan[i].arg, plan[i].known,
                                 plan[i].sample);
        ROW_SET_COUNT: write_reg(REG_TONE_COUNT, plan[i].arg[14:0]);
        default:       write_reg(REG_AMPLITUDE, plan[i].arg[14:0]);
      endcase
    end

    // Random phases, each under its own tone count and amplitude, extremes included.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       begin cnt = 5'd16; amp = 15'd32767; end
        1:       begin cnt = 5'd31; amp = 15'($urandom); end
        2:       begin cnt = 5'd0;  amp = 15'd1; end
        3:       begin cnt = 5'd1;  amp = 15'd32767; end
        4:       begin cnt = 5'($urandom_range(2, 15));  amp = 15'($urandom); end
        5:       begin cnt = 5'($urandom_range(17, 30)); amp = 15'($urandom); end
        6:       begin cnt = 5'($urandom_range(0, 31));  amp = 15'($urandom); end
        default: begin cnt = 5'($urandom_range(1, 16));  amp = 15'd16384; end
      endcase
      // Bits above the tone count field carry noise; the register keeps only five.
      write_reg(REG_TONE_COUNT, {10'($urandom), cnt});
      write_reg(REG_AMPLITUDE, amp);
      eff = (cnt == 5'd0) ? 1 : ((cnt > TONES) ? TONES : cnt);

      for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
        if (sent < RANDOM_ITEMS / 3) begin
          src_idle_pct  = 13;
          sink_idle_pct = 79;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          src_idle_pct  = 79;
          sink_idle_pct = 13;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        case ($urandom_range(9))
          0:       step = 32'h0;
          1:       step = 32'hFFFF_FFFF;
          2:       step = $urandom;
          3:       step = 32'hFFFF_FFFF - $urandom_range(0, 32'h0080_0000);
          default: step = $urandom_range(0, 32'h0800_0000);
        endcase
        // A tick never reads a step that has not been loaded, so a missing one goes first.
        missing = -1;
        for (int j = TONES - 1; j >= 0; j--) begin
          if (j < eff && !loaded[j]) missing = j;
        end
        if (missing >= 0) begin
          send_item(OP_LOAD, 4'(missing), step, 1'b0, 16'sd0);
        end else if ($urandom_range(99) < 75) begin
          send_item(OP_TICK, 4'($urandom), $urandom, 1'b0, 16'sd0);
        end else begin
          send_item(OP_LOAD, 4'($urandom), step, 1'b0, 16'sd0);
        end
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("multi_tone_sine_synth_tb OK");
    end else begin
      $display("multi_tone_sine_synth_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/msts_pkg.sv
design/msts_tone_cell.sv
design/msts_div.sv
design/multi_tone_sine_synth.sv
tb/sv/multi_tone_sine_synth_tb.sv
